/* src/serial_loaded_bank_mapper_macros.svh */
// Assertion macros for the serial loaded bank mapper.
// They assume a clock named i_clk and an active low reset named i_rst_n.
`ifndef SERIAL_LOADED_BANK_MAPPER_MACROS_SVH
`define SERIAL_LOADED_BANK_MAPPER_MACROS_SVH

`ifndef SYNTHESIS
`define SMB_ASSERT(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);
`define SMB_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SMB_ASSERT(name, cond, msg)
`define SMB_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

/* src/smb_pkg.sv */
package smb_pkg;

    localparam int WORK_RAM_DEPTH = 8192;
    localparam int ROM_ADDR_BITS  = 18;
    localparam int RAM_IDX_W      = $clog2(WORK_RAM_DEPTH);

    localparam logic [15:0] RAM_BASE = 16'h6000;
    localparam logic [18:0] PRG_MASK = 19'((32'd1 << ROM_ADDR_BITS) - 32'd1);

    localparam logic [1:0] OP_CPU_RD = 2'd0;
    localparam logic [1:0] OP_CPU_WR = 2'd1;
    localparam logic [1:0] OP_PPU_RD = 2'd2;
    localparam logic [1:0] OP_PPU_WR = 2'd3;

    localparam logic [1:0] REG_CONTROL = 2'd0;
    localparam logic [1:0] REG_CHR0    = 2'd1;
    localparam logic [1:0] REG_CHR1    = 2'd2;
    localparam logic [1:0] REG_PRG     = 2'd3;

    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_CHR_IS_RAM     = 1'b1;

    typedef struct packed {
        logic                 en;
        logic [RAM_IDX_W-1:0] idx;
        logic [7:0]           data;
    } t_ram_wr;

endpackage

/* src/smb_ram.sv */
module smb_ram (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [smb_pkg::RAM_IDX_W-1:0] i_rd_idx,
    input  smb_pkg::t_ram_wr             i_wr,
    output logic [7:0]                   o_rd_data
);
    import smb_pkg::*;

    logic [7:0] r_mem [WORK_RAM_DEPTH];
    logic [7:0] r_rd_data;
    logic       r_byp;
    logic [7:0] r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
    end

    // A write landing in the same cycle as the read must win over the old contents.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_byp      <= i_wr.en && (i_wr.idx == i_rd_idx);
            r_byp_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_data;

endmodule

/* src/serial_loaded_bank_mapper.sv */
// Transfers are registered in stage 1 and then in the output registers. Throughput:
// one access per clock unless stalled, limited by the single port pair of the work RAM.
// A full output register with a stalled consumer holds the stage behind it.
// Reset is synchronous and active low; it restores the mapper registers to
// program mode 3 and clears the serial loader. Work RAM contents are not reset.
`include "serial_loaded_bank_mapper_macros.svh"

module serial_loaded_bank_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_bus_addr,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_rom_mapped,
    output logic [17:0] o_translated_addr,
    output logic        o_ram_hit,
    output logic [7:0]  o_read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import smb_pkg::*;

    logic [4:0]  r_prg_bank_count;
    logic        r_chr_is_ram;

    logic        r_s1_valid;
    logic [1:0]  r_op;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic        r_out_valid;

    logic [4:0]  r_shift_bits, n_shift_bits;
    logic [2:0]  r_shift_count, n_shift_count;
    logic [4:0]  r_control, n_control;
    logic [4:0]  r_chr0, n_chr0;
    logic [4:0]  r_chr1, n_chr1;
    logic [3:0]  r_prog_bank, n_prog_bank;
    logic        r_ram_disabled, n_ram_disabled;

    logic        in_acc;
    logic        s1_adv;
    logic        cfg_wr;
    logic        in_ram;
    logic        reg_wr;
    logic [7:0]  ram_rd_data;
    logic [15:0] rd_off;
    logic [15:0] s1_off;
    t_ram_wr     ram_wr;
    logic [4:0]  prg_bank;
    logic [18:0] prg_full;
    logic [17:0] prg_addr;
    logic [17:0] chr_addr;
    logic [4:0]  shifted;
    logic [2:0]  count_inc;

    logic        n_mapped;
    logic [17:0] n_taddr;
    logic        n_hit;
    logic [7:0]  n_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= 5'd16;
            r_chr_is_ram     <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_PRG_BANK_COUNT: r_prg_bank_count <= pwdata[4:0];
                CFG_CHR_IS_RAM:     r_chr_is_ram     <= pwdata[0];
                default:            r_chr_is_ram     <= r_chr_is_ram;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_PRG_BANK_COUNT: prdata = {27'd0, r_prg_bank_count};
            CFG_CHR_IS_RAM:     prdata = {31'd0, r_chr_is_ram};
            default:            prdata = 32'd0;
        endcase
    end

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= in_acc || o_in_stall;
            r_out_valid <= s1_adv || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_opcode;
            r_addr  <= i_bus_addr;
            r_wdata <= i_write_data;
        end
    end

    // The RAM is read speculatively when a transfer is accepted.
    assign rd_off = i_bus_addr - RAM_BASE;
    assign s1_off = r_addr - RAM_BASE;
    assign in_ram = (r_addr[15:13] == 3'b011) && !r_ram_disabled;

    assign ram_wr.en   = s1_adv && (r_op == OP_CPU_WR) && in_ram;
    assign ram_wr.idx  = s1_off[RAM_IDX_W-1:0];
    assign ram_wr.data = r_wdata;

    smb_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_idx  (rd_off[RAM_IDX_W-1:0]),
        .i_wr      (ram_wr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        prg_bank = {1'b0, r_prog_bank};
        prg_full = {1'b0, r_prog_bank[3:1], r_addr[14:0]};
        if (r_control[3:2] == 2'b10) begin
            prg_bank = r_addr[14] ? {1'b0, r_prog_bank} : 5'd0;
            prg_full = {prg_bank, r_addr[13:0]};
        end else if (r_control[3:2] == 2'b11) begin
            prg_bank = r_addr[14] ? 5'(r_prg_bank_count - 5'd1) : {1'b0, r_prog_bank};
            prg_full = {prg_bank, r_addr[13:0]};
        end
        prg_addr = 18'(prg_full & PRG_MASK);
    end

    always_comb begin
        if (!r_control[4]) begin
            chr_addr = {1'b0, r_chr0[4:1], r_addr[12:0]};
        end else if (r_addr[12]) begin
            chr_addr = {1'b0, r_chr1, r_addr[11:0]};
        end else begin
            chr_addr = {1'b0, r_chr0, r_addr[11:0]};
        end
    end

    always_comb begin
        n_mapped = 1'b0;
        n_taddr  = 18'd0;
        n_hit    = 1'b0;
        n_rdata  = 8'd0;
        unique case (r_op)
            OP_CPU_RD: begin
                if (in_ram) begin
                    n_hit   = 1'b1;
                    n_rdata = ram_rd_data;
                end else if (r_addr[15]) begin
                    n_mapped = 1'b1;
                    n_taddr  = prg_addr;
                end
            end
            OP_CPU_WR: begin
                n_hit = in_ram;
            end
            OP_PPU_RD, OP_PPU_WR: begin
                if (r_addr[15:13] == 3'b000) begin
                    if (r_chr_is_ram) begin
                        n_mapped = 1'b1;
                        n_taddr  = {2'b00, r_addr};
                    end else if (r_op == OP_PPU_RD) begin
                        n_mapped = 1'b1;
                        n_taddr  = chr_addr;
                    end
                end
            end
            default: n_mapped = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_rom_mapped      <= n_mapped;
            o_translated_addr <= n_taddr;
            o_ram_hit         <= n_hit;
            o_read_data       <= n_rdata;
        end
    end

    assign o_out_valid = r_out_valid;

    assign reg_wr    = s1_adv && (r_op == OP_CPU_WR) && r_addr[15];
    assign shifted   = {r_wdata[0], r_shift_bits[4:1]};
    assign count_inc = 3'(r_shift_count + 3'd1);

    always_comb begin
        n_shift_bits   = r_shift_bits;
        n_shift_count  = r_shift_count;
        n_control      = r_control;
        n_chr0         = r_chr0;
        n_chr1         = r_chr1;
        n_prog_bank    = r_prog_bank;
        n_ram_disabled = r_ram_disabled;
        if (reg_wr) begin
            if (r_wdata[7]) begin
                n_shift_bits  = 5'd0;
                n_shift_count = 3'd0;
                n_control     = r_control | 5'h0C;
            end else if (count_inc >= 3'd5) begin
                n_shift_bits  = 5'd0;
                n_shift_count = 3'd0;
                unique case (r_addr[14:13])
                    REG_CONTROL: n_control = shifted;
                    REG_CHR0:    n_chr0    = shifted;
                    REG_CHR1:    n_chr1    = shifted;
                    REG_PRG: begin
                        n_prog_bank    = shifted[3:0];
                        n_ram_disabled = shifted[4];
                    end
                    default: n_control = r_control;
                endcase
            end else begin
                n_shift_bits  = shifted;
                n_shift_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_bits   <= 5'd0;
            r_shift_count  <= 3'd0;
            r_control      <= 5'h0C;
            r_chr0         <= 5'd0;
            r_chr1         <= 5'd0;
            r_prog_bank    <= 4'd0;
            r_ram_disabled <= 1'b0;
        end else begin
            r_shift_bits   <= n_shift_bits;
            r_shift_count  <= n_shift_count;
            r_control      <= n_control;
            r_chr0         <= n_chr0;
            r_chr1         <= n_chr1;
            r_prog_bank    <= n_prog_bank;
            r_ram_disabled <= n_ram_disabled;
        end
    end

    `SMB_ASSERT(a_shift_count_range, r_shift_count <= 3'd4, "Serial loader count passed four.")
    `SMB_ASSERT_NEXT(a_adv_fills_out, s1_adv, r_out_valid, "Advanced transfer lost its result.")
    `SMB_ASSERT_NEXT(a_reset_write_mode, reg_wr && r_wdata[7],
        (r_control[3:2] == 2'b11) && (r_shift_count == 3'd0),
        "Loader reset write did not force program mode 3.")
    `SMB_ASSERT(a_ram_write_only_hit, !ram_wr.en || (r_s1_valid && !r_ram_disabled),
        "Work RAM written while disabled or without a transfer.")

endmodule
